[rtl/pressure_temp_compensation_macros.svh]
// ----------------------------------------------------------------------------
// pressure temperature compensation assertion macros
// concurrent assertion helpers, removed when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PTC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTC_ASSERT(lbl, clk, rstn, prop)
`define PTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// shared types, constants and helpers of the pressure compensation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int DIV_STAGES = 32;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } cfg_reg_e;

  // side data traveling next to the temperature divider
  typedef struct packed {
    logic               vld;
    logic               fault;
    logic               neg;
    logic signed [31:0] x1;
    logic [23:0]        up;
  } div_t_side_t;

  // side data traveling next to the pressure divider
  typedef struct packed {
    logic               vld;
    logic               fault;
    logic               wide;
    logic signed [31:0] t;
  } div_p_side_t;

  // signed division by 2**sh, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v,
                                                 input logic [4:0] sh);
    logic signed [31:0] bias;
    bias = (32'sd1 <<< sh) - 32'sd1;
    return (v + (v[31] ? bias : 32'sd0)) >>> sh;
  endfunction

endpackage

[rtl/ptc_if.sv]
// ----------------------------------------------------------------------------
// ptc channel interfaces
// valid/ready channels for raw samples and compensated results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic               divide_fault;
  modport source (output valid, output temperature_tenths, output pressure_pa,
                  output divide_fault, input ready);
  modport sink (input valid, input temperature_tenths, input pressure_pa,
                input divide_fault, output ready);
endinterface

[rtl/ptc_udiv.sv]
// ----------------------------------------------------------------------------
// ptc_udiv
// pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_udiv
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q [DIV_STAGES];
  logic [31:0] quo_q [DIV_STAGES];
  logic [31:0] dvs_q [DIV_STAGES];
  logic [31:0] rem_d [DIV_STAGES];
  logic [31:0] quo_d [DIV_STAGES];
  logic [31:0] dvs_d [DIV_STAGES];

  always_comb begin
    logic [31:0] r;
    logic [31:0] q;
    logic [31:0] d;
    logic [32:0] trial;
    logic        ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        r = '0;
        q = dividend_i;
        d = divisor_i;
      end else begin
        r = rem_q[i-1];
        q = quo_q[i-1];
        d = dvs_q[i-1];
      end
      trial = {r, q[31]};
      ge = trial >= {1'b0, d};
      rem_d[i] = ge ? 32'(trial - {1'b0, d}) : trial[31:0];
      quo_d[i] = {q[30:0], ge};
      dvs_d[i] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_d;
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

[rtl/pressure_temp_compensation.sv]
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// integer compensation of raw temperature and pressure samples
// ----------------------------------------------------------------------------
// Takes one raw sample per cycle unless stalled and returns temperature in
// tenths of a degree and pressure in pascals. Two 32-stage restoring dividers,
// one bit per stage, set the depth; the rest is short multiply and shift
// stages. The whole pipeline advances whenever the output register is empty
// or taken, so a stall holds every item in place. Coefficients must be written
// through the plain write port only while idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "pressure_temp_compensation_macros.svh"

module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ptc_in_if.sink      in_i,
  ptc_out_if.source   out_o
);

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AC1_AC2: ac12_q <= cfg_data_i;
        REG_AC3_AC4: ac34_q <= cfg_data_i;
        REG_AC5_AC6: ac56_q <= cfg_data_i;
        REG_B1_B2:   b12_q  <= cfg_data_i;
        REG_MC_MD:   mcmd_q <= cfg_data_i;
        REG_OSS:     oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;
  assign ac1 = 32'(signed'(ac12_q[31:16]));
  assign ac2 = 32'(signed'(ac12_q[15:0]));
  assign ac3 = 32'(signed'(ac34_q[31:16]));
  assign ac4 = ac34_q[15:0];
  assign ac5 = ac56_q[31:16];
  assign ac6 = ac56_q[15:0];
  assign b1  = 32'(signed'(b12_q[31:16]));
  assign b2  = 32'(signed'(b12_q[15:0]));
  assign mc  = 32'(signed'(mcmd_q[31:16]));
  assign md  = 32'(signed'(mcmd_q[15:0]));

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // front stages
  logic               v1_q, v2_q, v3_q;
  logic [15:0]        ut1_q;
  logic [23:0]        up1_q, up2_q, up3_q;
  logic signed [31:0] pr2_q, x13_q, den3_q, num3_q;

  // middle stages
  logic               v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic               f4_q, f5_q, f6_q, f7_q, f8_q, f9_q, f10_q, f11_q;
  logic [23:0]        up4_q, up5_q, up6_q, up7_q, up8_q, up9_q;
  logic signed [31:0] t4_b5_q;
  logic signed [31:0] t5_q, t6_q, t7_q, t8_q, t9_q, t10_q, t11_q;
  logic signed [31:0] psq5_q, pac2_q, pac3_q;
  logic signed [31:0] sq6_q, xa6_q, xc6_q, xa7_q, xc7_q, m1_7_q, m2_7_q;
  logic signed [31:0] x3_8_q, s8_q, b3_9_q, x3b9_q;
  logic [31:0]        b4p10_q, b7a10_q, b4_11_q, b7_11_q;

  // back stages
  logic               v12_q, v13_q, v14_q, v15_q, v16_q, vo_q;
  logic               f12_q, f13_q, f14_q, f15_q, f16_q, fo_q;
  logic signed [31:0] t12_q, t13_q, t14_q, t15_q, t16_q, to_q;
  logic signed [31:0] p12_q, p13_q, p14_q, p15_q, p16_q, po_q;
  logic signed [31:0] a13_q, x2p13_q, x2p14_q, x2p15_q;
  logic signed [31:0] sqa14_q, x1m15_q, s16_q;

  // temperature divider
  div_t_side_t        sa_q [DIV_STAGES];
  logic [31:0]        qa;
  logic signed [31:0] x1_3, den_3;
  div_t_side_t        sa_in;

  assign x1_3  = sdiv_p2(pr2_q, 5'd15);
  assign den_3 = x1_3 + md;
  assign sa_in = '{vld: v3_q, fault: den3_q == 32'sd0, neg: num3_q[31] ^ den3_q[31],
                   x1: x13_q, up: up3_q};

  ptc_udiv u_div_t (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (num3_q[31] ? 32'(-num3_q) : num3_q),
    .divisor_i  (den3_q[31] ? 32'(-den3_q) : den3_q),
    .quotient_o (qa)
  );

  // pressure divider
  div_p_side_t sb_q [DIV_STAGES];
  logic [31:0] qb;
  div_p_side_t sb_in;

  assign sb_in = '{vld: v11_q, fault: f11_q, wide: b7_11_q[31], t: t11_q};

  ptc_udiv u_div_p (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (b7_11_q[31] ? b7_11_q : {b7_11_q[30:0], 1'b0}),
    .divisor_i  (b4_11_q),
    .quotient_o (qb)
  );

  logic signed [31:0] b6_c, b3_c;
  logic [31:0]        b4_c;
  assign b6_c = t4_b5_q - 32'sd4000;
  assign b3_c = 32'(((ac1 <<< 2) + x3_8_q) <<< oss_q);
  assign b4_c = b4p10_q >> 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; v12_q <= 1'b0;
      v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0; v16_q <= 1'b0;
      vo_q <= 1'b0;
      sa_q <= '{default: '0};
      sb_q <= '{default: '0};
    end else if (en) begin
      v1_q  <= in_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      sa_q[0] <= sa_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
      v4_q  <= sa_q[DIV_STAGES-1].vld;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      sb_q[0] <= sb_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      v12_q <= sb_q[DIV_STAGES-1].vld;
      v13_q <= v12_q;
      v14_q <= v13_q;
      v15_q <= v14_q;
      v16_q <= v15_q;
      vo_q  <= v16_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ut1_q  <= in_i.raw_temperature;
      up1_q  <= in_i.raw_pressure >> (4'd8 - {2'b00, oss_q});
      // temperature front
      up2_q  <= up1_q;
      pr2_q  <= 32'((signed'({1'b0, ut1_q}) - signed'({1'b0, ac6}))
                    * signed'({1'b0, ac5}));
      up3_q  <= up2_q;
      x13_q  <= x1_3;
      den3_q <= den_3;
      num3_q <= mc <<< 11;
      // after temperature divider
      f4_q    <= sa_q[DIV_STAGES-1].fault;
      up4_q   <= sa_q[DIV_STAGES-1].up;
      t4_b5_q <= sa_q[DIV_STAGES-1].x1
                 + (sa_q[DIV_STAGES-1].neg ? 32'(-qa) : qa);
      f5_q   <= f4_q;
      up5_q  <= up4_q;
      t5_q   <= sdiv_p2(t4_b5_q + 32'sd8, 5'd4);
      psq5_q <= 32'(b6_c * b6_c);
      pac2_q <= 32'(ac2 * b6_c);
      pac3_q <= 32'(ac3 * b6_c);
      f6_q  <= f5_q;
      up6_q <= up5_q;
      t6_q  <= t5_q;
      sq6_q <= sdiv_p2(psq5_q, 5'd12);
      xa6_q <= sdiv_p2(pac2_q, 5'd11);
      xc6_q <= sdiv_p2(pac3_q, 5'd13);
      f7_q   <= f6_q;
      up7_q  <= up6_q;
      t7_q   <= t6_q;
      xa7_q  <= xa6_q;
      xc7_q  <= xc6_q;
      m1_7_q <= 32'(b2 * sq6_q);
      m2_7_q <= 32'(b1 * sq6_q);
      f8_q   <= f7_q;
      up8_q  <= up7_q;
      t8_q   <= t7_q;
      x3_8_q <= sdiv_p2(m1_7_q, 5'd11) + xa7_q;
      s8_q   <= xc7_q + sdiv_p2(m2_7_q, 5'd16);
      f9_q   <= f8_q;
      up9_q  <= up8_q;
      t9_q   <= t8_q;
      b3_9_q <= sdiv_p2(b3_c + 32'sd2, 5'd2);
      x3b9_q <= sdiv_p2(s8_q + 32'sd2, 5'd2);
      f10_q   <= f9_q;
      t10_q   <= t9_q;
      b4p10_q <= 32'({16'b0, ac4} * 32'(x3b9_q + 32'sd32768));
      b7a10_q <= {8'b0, up9_q} - 32'(b3_9_q);
      f11_q   <= f10_q || (b4_c == 32'd0);
      t11_q   <= t10_q;
      b4_11_q <= b4_c;
      b7_11_q <= 32'(b7a10_q * (32'd50000 >> oss_q));
      // after pressure divider
      f12_q <= sb_q[DIV_STAGES-1].fault;
      t12_q <= sb_q[DIV_STAGES-1].t;
      p12_q <= sb_q[DIV_STAGES-1].wide ? {qb[30:0], 1'b0} : qb;
      f13_q   <= f12_q;
      t13_q   <= t12_q;
      p13_q   <= p12_q;
      a13_q   <= sdiv_p2(p12_q, 5'd8);
      x2p13_q <= 32'(-32'sd7357 * p12_q);
      f14_q   <= f13_q;
      t14_q   <= t13_q;
      p14_q   <= p13_q;
      x2p14_q <= x2p13_q;
      sqa14_q <= 32'(a13_q * a13_q);
      f15_q   <= f14_q;
      t15_q   <= t14_q;
      p15_q   <= p14_q;
      x2p15_q <= x2p14_q;
      x1m15_q <= 32'(sqa14_q * 32'sd3038);
      f16_q <= f15_q;
      t16_q <= t15_q;
      p16_q <= p15_q;
      s16_q <= sdiv_p2(x1m15_q, 5'd16) + sdiv_p2(x2p15_q, 5'd16) + 32'sd3791;
      fo_q <= f16_q;
      to_q <= f16_q ? 32'sd0 : t16_q;
      po_q <= f16_q ? 32'sd0 : p16_q + sdiv_p2(s16_q, 5'd4);
    end
  end

  assign out_o.valid              = vo_q;
  assign out_o.temperature_tenths = to_q;
  assign out_o.pressure_pa        = po_q;
  assign out_o.divide_fault       = fo_q;

  `PTC_ASSERT(a_fault_zero, clk_i, rst_ni, out_o.valid && out_o.divide_fault |-> out_o.temperature_tenths == 32'sd0 && out_o.pressure_pa == 32'sd0)
  `PTC_ASSERT_NEXT(a_take, clk_i, rst_ni, in_i.valid && in_i.ready, v1_q)
  `PTC_ASSERT_NEXT(a_hold, clk_i, rst_ni, !in_i.ready, $stable(sa_q[DIV_STAGES-1]) && $stable(sb_q[DIV_STAGES-1]))
  `PTC_ASSERT_NEXT(a_div_fault, clk_i, rst_ni, in_i.ready && v11_q && b4_11_q == 32'd0, sb_q[0].fault)

endmodule
